@@ hdl/fbfl_pkg.sv @@
// shared constants, types and helpers of the fixed block free list allocator
// no dependencies
package fbfl_pkg;

    localparam int NUM_BLOCKS = 64;
    // alignment in bytes, a power of two
    localparam int ALIGN      = 16;

    localparam int LINK_AW    = $clog2(NUM_BLOCKS);
    localparam int LINK_W     = $clog2(NUM_BLOCKS + 1);
    localparam int INDEX_W    = 6;
    localparam int BSIZE_W    = 13;
    localparam int ASIZE_W    = BSIZE_W + 1;
    localparam int OFFSET_W   = 18;
    localparam int COUNT_W    = 7;
    localparam int PROD_W     = INDEX_W + ASIZE_W;

    localparam logic [LINK_W-1:0]  NULL_LINK  = LINK_W'(NUM_BLOCKS);
    localparam logic [BSIZE_W-1:0] BSIZE_RST  = BSIZE_W'(64);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic load;   // latch the accepted word and read the head link
        logic exec;   // update the list and load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;  // output register empty or being taken
    } t_dp_stat;

    // block size rounded up to a multiple of the alignment
    function automatic logic [ASIZE_W-1:0] align_up(input logic [BSIZE_W-1:0] bs);
        logic [ASIZE_W-1:0] sum;
        sum = {1'b0, bs} + ASIZE_W'(ALIGN - 1);
        return sum & ~ASIZE_W'(ALIGN - 1);
    endfunction

endpackage

@@ hdl/fbfl_ram.sv @@
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fbfl_ctrl.sv @@
// controller of the allocator: accept, then execute once the output slot is free
// depends on fbfl_pkg
module fbfl_ctrl import fbfl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.slot_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/fbfl_dp.sv @@
// datapath of the allocator: head, free counter, link ram with valid bits, output register
// depends on fbfl_pkg and fbfl_ram
module fbfl_dp import fbfl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_command,
    input  logic [INDEX_W-1:0]   i_block_index,
    input  logic                 i_is_null,
    input  logic [ASIZE_W-1:0]   i_align_size,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_granted,
    output logic [INDEX_W-1:0]   o_given_index,
    output logic [OFFSET_W-1:0]  o_byte_offset,
    output logic [COUNT_W-1:0]   o_free_count
);

    logic                r_command;
    logic [INDEX_W-1:0]  r_idx;
    logic                r_null;
    logic [LINK_W-1:0]   r_head;
    logic [LINK_W-1:0]   n_head;
    logic [COUNT_W-1:0]  r_free;
    logic [COUNT_W-1:0]  n_free;
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [LINK_AW-1:0]  r_rd_addr;
    logic                r_rd_valid;
    logic                r_out_valid;
    logic                r_granted;
    logic [INDEX_W-1:0]  r_given;
    logic [OFFSET_W-1:0] r_offset;

    logic [LINK_W-1:0]   ram_q;
    logic [LINK_W-1:0]   link_val;
    logic                do_pop;
    logic                do_push;
    logic [PROD_W-1:0]   product;

    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_idx[LINK_AW-1:0]),
        .i_wdata (r_head),
        .i_re    (i_cmd.load),
        .i_raddr (r_head[LINK_AW-1:0]),
        .o_rdata (ram_q)
    );

    // entries never written hold their reset link, i minus one, null for block 0
    always_comb begin
        if (r_rd_valid) begin
            link_val = ram_q;
        end else if (r_rd_addr == '0) begin
            link_val = NULL_LINK;
        end else begin
            link_val = LINK_W'(r_rd_addr) - LINK_W'(1);
        end
    end

    assign do_pop  = i_cmd.exec && (r_command == CMD_ALLOC) && (r_head < NULL_LINK);
    assign do_push = i_cmd.exec && (r_command == CMD_RELEASE) && !r_null
                     && (LINK_W'(r_idx) < NULL_LINK);

    assign product = PROD_W'(r_head[INDEX_W-1:0]) * PROD_W'(i_align_size);

    always_comb begin
        n_head = r_head;
        n_free = r_free;
        if (do_pop) begin
            n_head = link_val;
            if (r_free != '0) begin
                n_free = r_free - COUNT_W'(1);
            end
        end else if (do_push) begin
            n_head = LINK_W'(r_idx);
            if (r_free < COUNT_W'(NUM_BLOCKS)) begin
                n_free = r_free + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= LINK_W'(NUM_BLOCKS - 1);
            r_free      <= COUNT_W'(NUM_BLOCKS);
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_free <= n_free;
            if (do_push) begin
                r_valid[r_idx[LINK_AW-1:0]] <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command  <= i_command;
            r_idx      <= i_block_index;
            r_null     <= i_is_null;
            r_rd_addr  <= r_head[LINK_AW-1:0];
            r_rd_valid <= r_valid[r_head[LINK_AW-1:0]];
        end
        if (i_cmd.exec) begin
            r_granted <= do_pop;
            r_given   <= do_pop ? r_head[INDEX_W-1:0] : '0;
            r_offset  <= do_pop ? product[OFFSET_W-1:0] : '0;
        end
    end

    assign o_stat.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_granted;
    assign o_given_index    = r_given;
    assign o_byte_offset    = r_offset;
    assign o_free_count     = r_free;

endmodule

@@ hdl/fixed_block_free_list_allocator.sv @@
// top level of the fixed block free list allocator: apb register, controller, datapath
// depends on fbfl_pkg, fbfl_ctrl, fbfl_dp (and through it fbfl_ram)
//
// usage
// - input stream: one word per command, allocate or release; tuser carries the
//   command and the null flag, tdata the block index to release
// - output stream: exactly one word per input word, in order: granted, the
//   given block index, its byte offset and the free count after the command
// - config: one apb register at byte address 0, block_size; write it only
//   while no command is in flight
// - timing: an accepted word is latched while the head link is read; the exec state then
//   updates the list and loads the output register once that register is free
// - pacing: no new command is taken until the last one has executed, since the registered
//   read of the link ram must return the next link before the head can move
// - stall: the result sits in the output register while the receiver holds
//   tready low; one more word is accepted and then waits until the slot frees
// - reset: the free list links block 63 down to block 0, all 64 blocks free,
//   block_size 64; link ram contents come from per-entry valid bits, no sweep
module fixed_block_free_list_allocator import fbfl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [5:0] block_index, [7:6] zero
    input  logic [1:0]  i_s_tuser,   // [0] command, [1] is_null
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [0] granted, [6:1] given_index,
                                     // [24:7] byte_offset, [31:25] free_count
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_BLOCK_SIZE = 1'b0;

    logic [BSIZE_W-1:0] r_block_size;
    logic [ASIZE_W-1:0] r_align_size;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic                granted;
    logic [INDEX_W-1:0]  given_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_count;
    logic                cfg_write;

    // register access, the aligned size is kept alongside so the datapath sees a flop
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BLOCK_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BSIZE_RST;
            r_align_size <= align_up(BSIZE_RST);
        end else if (cfg_write) begin
            r_block_size <= pwdata[BSIZE_W-1:0];
            r_align_size <= align_up(pwdata[BSIZE_W-1:0]);
        end
    end

    assign prdata = (paddr[2] == REG_BLOCK_SIZE) ? 32'(r_block_size) : 32'd0;

    fbfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    fbfl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_s_tuser[0]),
        .i_block_index (i_s_tdata[INDEX_W-1:0]),
        .i_is_null     (i_s_tuser[1]),
        .i_align_size  (r_align_size),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_granted     (granted),
        .o_given_index (given_index),
        .o_byte_offset (byte_offset),
        .o_free_count  (free_count)
    );

    // result word, highest field first
    assign o_m_tdata = {free_count, byte_offset, given_index, granted};

endmodule
